// ===== rtl/hglf_pkg.sv =====
// Shared types and constants for the histogram gap filler.
package hglf_pkg;

    localparam int MAX_GAP_DEF    = 63;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FIELD_W        = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_DIV,
        S_INTERP,
        S_SELF
    } t_state;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ZERO,
        EMIT_INTERP,
        EMIT_SELF
    } t_emit;

    typedef struct packed {
        logic  accept;
        logic  div_start;
        logic  interp_init;
        t_emit emit;
        logic  run_last;
        logic  done;
        logic  abandoned;
    } t_cmd;

    typedef struct packed {
        logic bin_zero;
        logic slot_free;
        logic div_done;
    } t_status;

endpackage

// ===== rtl/histogram_gap_linear_fill.sv =====
// Top level of the histogram gap filler: controller plus datapath.
//
// Bins of a histogram enter on the input channel (i_in_valid, o_in_stall) one
// item at a time, the underflow bin first. Results leave on the output channel
// (o_out_valid, i_out_stall) with o_run_last marking the final result caused
// by an input item; many input items cause no result at all.
// A zero bin is held in a pending gap. A nonzero bin that closes a gap
// of n-1 held bins starts a shift-subtract divider that works out
// |bin - anchor| / n at one quotient bit per cycle. The held bins are then
// emitted one per cycle while the output is not stalled, from a running
// quotient and remainder, followed by the bin itself. Flushed zeros also
// go out one per cycle while the output is not stalled.
// The block works on one item at a time: o_in_stall is high from the cycle
// after an item that causes results is accepted until its last result is
// loaded into the output register, so the next item is taken while that
// result still waits. A stalled output holds its result and freezes the sequencing.
// Synchronous reset (i_rst_n low) empties the output register, clears the
// anchor, the pending gap count and the abandoned-gap mode; the input channel
// stalls while reset is held.
module histogram_gap_linear_fill import hglf_pkg::*; #(
    parameter int MAX_GAP    = MAX_GAP_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [FIELD_W-1:0] i_bin_value,
    input  logic               i_is_underflow,
    input  logic               i_is_last_bin,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_filled_value,
    output logic               o_run_last,
    output logic               o_histogram_done,
    output logic               o_gap_abandoned
);

    localparam int CW = $clog2(MAX_GAP + 1);

    t_cmd          cmd;
    t_status       status;
    logic [CW-1:0] div_n;

    // The controller decodes each item against the gap state and steps
    // through the zero flush, division, interpolation and final-bin phases.
    hglf_ctrl #(
        .MAX_GAP (MAX_GAP)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_is_underflow (i_is_underflow),
        .i_is_last_bin  (i_is_last_bin),
        .i_status       (status),
        .o_in_stall     (o_in_stall),
        .o_cmd          (cmd),
        .o_div_n        (div_n)
    );

    // The datapath holds the anchor, the divider and the output register.
    hglf_dp #(
        .MAX_GAP    (MAX_GAP),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_bin_value      (i_bin_value),
        .i_is_underflow   (i_is_underflow),
        .i_is_last_bin    (i_is_last_bin),
        .i_cmd            (cmd),
        .i_div_n          (div_n),
        .i_out_stall      (i_out_stall),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_filled_value   (o_filled_value),
        .o_run_last       (o_run_last),
        .o_histogram_done (o_histogram_done),
        .o_gap_abandoned  (o_gap_abandoned)
    );

endmodule

// ===== rtl/hglf_ctrl.sv =====
// Controller state machine: decodes each bin and sequences the results it causes.
module hglf_ctrl import hglf_pkg::*; #(
    parameter int MAX_GAP = MAX_GAP_DEF,
    localparam int CW     = $clog2(MAX_GAP + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_is_underflow,
    input  logic          i_is_last_bin,
    input  t_status       i_status,
    output logic          o_in_stall,
    output t_cmd          o_cmd,
    output logic [CW-1:0] o_div_n
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_abandon, n_abandon;
    logic [CW-1:0] r_left, n_left;
    logic          r_zero_ab, n_zero_ab;
    logic          r_self_en, n_self_en;
    logic          r_self_done, n_self_done;
    logic          r_self_ab, n_self_ab;

    logic          accept;
    logic [CW-1:0] count_inc;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign count_inc  = r_count + CW'(1);
    assign o_div_n    = count_inc;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_abandon   = r_abandon;
        n_left      = r_left;
        n_zero_ab   = r_zero_ab;
        n_self_en   = r_self_en;
        n_self_done = r_self_done;
        n_self_ab   = r_self_ab;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_is_underflow) begin
                        n_count   = '0;
                        n_abandon = 1'b0;
                        n_left    = r_count;
                        n_zero_ab = 1'b0;
                        n_self_en = 1'b0;
                        if (r_count != '0) begin
                            n_state = S_ZERO;
                        end
                    end else if (i_status.bin_zero) begin
                        if (r_abandon) begin
                            n_state     = S_SELF;
                            n_self_done = i_is_last_bin;
                            n_self_ab   = 1'b1;
                        end else if (i_is_last_bin) begin
                            n_left      = r_count;
                            n_zero_ab   = 1'b0;
                            n_self_en   = 1'b1;
                            n_self_done = 1'b1;
                            n_self_ab   = 1'b0;
                            n_state     = (r_count != '0) ? S_ZERO : S_SELF;
                        end else if (count_inc >= CW'(MAX_GAP)) begin
                            n_left    = count_inc;
                            n_zero_ab = 1'b1;
                            n_self_en = 1'b0;
                            n_count   = '0;
                            n_abandon = 1'b1;
                            n_state   = S_ZERO;
                        end else begin
                            n_count = count_inc;
                        end
                    end else begin
                        n_left      = r_count;
                        n_self_done = i_is_last_bin;
                        n_self_ab   = 1'b0;
                        n_count     = '0;
                        n_abandon   = 1'b0;
                        n_state     = (r_count != '0) ? S_DIV : S_SELF;
                    end
                    // The last bin of a histogram leaves the gap state empty.
                    if (!i_is_underflow && i_is_last_bin) begin
                        n_count   = '0;
                        n_abandon = 1'b0;
                    end
                end
            end
            S_ZERO: begin
                if (i_status.slot_free) begin
                    n_left = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = r_self_en ? S_SELF : S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_INTERP;
                end
            end
            S_INTERP: begin
                if (i_status.slot_free) begin
                    n_left = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_SELF;
                    end
                end
            end
            S_SELF: begin
                if (i_status.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.emit        = EMIT_NONE;
        o_cmd.accept      = accept;
        o_cmd.div_start   = accept && !i_is_underflow && !i_status.bin_zero
                            && (r_count != '0);
        case (r_state)
            S_ZERO: begin
                if (i_status.slot_free) begin
                    o_cmd.emit      = EMIT_ZERO;
                    o_cmd.abandoned = r_zero_ab;
                    o_cmd.run_last  = (r_left == CW'(1)) && !r_self_en;
                end
            end
            S_DIV: begin
                o_cmd.interp_init = i_status.div_done;
            end
            S_INTERP: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = EMIT_INTERP;
                end
            end
            S_SELF: begin
                if (i_status.slot_free) begin
                    o_cmd.emit      = EMIT_SELF;
                    o_cmd.done      = r_self_done;
                    o_cmd.abandoned = r_self_ab;
                    o_cmd.run_last  = 1'b1;
                end
            end
            default: begin
                o_cmd.emit = EMIT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_abandon <= 1'b0;
            r_left    <= '0;
            r_zero_ab <= 1'b0;
            r_self_en <= 1'b0;
            r_self_done <= 1'b0;
            r_self_ab <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_abandon <= n_abandon;
            r_left    <= n_left;
            r_zero_ab <= n_zero_ab;
            r_self_en <= n_self_en;
            r_self_done <= n_self_done;
            r_self_ab <= n_self_ab;
        end
    end

endmodule

// ===== rtl/hglf_dp.sv =====
// Datapath: anchor, shift-subtract divider, interpolation accumulators and output register.
module hglf_dp import hglf_pkg::*; #(
    parameter int MAX_GAP    = MAX_GAP_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CW        = $clog2(MAX_GAP + 1),
    localparam int VW        = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W,
    localparam int DCW       = $clog2(VW + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [FIELD_W-1:0] i_bin_value,
    input  logic               i_is_underflow,
    input  logic               i_is_last_bin,
    input  t_cmd               i_cmd,
    input  logic [CW-1:0]      i_div_n,
    input  logic               i_out_stall,
    output t_status            o_status,
    output logic               o_out_valid,
    output logic [FIELD_W-1:0] o_filled_value,
    output logic               o_run_last,
    output logic               o_histogram_done,
    output logic               o_gap_abandoned
);

    logic [VW-1:0]  in_v;
    logic [VW-1:0]  r_anchor;
    logic [VW-1:0]  r_bin;
    logic [VW-1:0]  r_base;
    logic           r_neg;
    logic [CW-1:0]  r_div_n;
    logic [VW-1:0]  r_quo;
    logic [CW-1:0]  r_rem;
    logic [DCW-1:0] r_div_cnt;
    logic [VW-1:0]  r_acc_q;
    logic [CW-1:0]  r_acc_r;
    logic           r_out_valid;
    logic [VW-1:0]  r_out_value;
    logic           r_out_last;
    logic           r_out_done;
    logic           r_out_ab;

    logic           in_neg;
    logic [VW-1:0]  in_mag;
    logic [CW:0]    rem_sh;
    logic           rem_ge;
    logic [CW:0]    rem_sub;
    logic [CW:0]    acc_sum;
    logic           acc_carry;
    logic [CW:0]    acc_sub;
    logic [VW-1:0]  interp_value;

    assign in_v   = i_bin_value[VW-1:0];
    assign in_neg = in_v < r_anchor;
    assign in_mag = in_neg ? (r_anchor - in_v) : (in_v - r_anchor);

    // One quotient bit per cycle.
    assign rem_sh  = {r_rem, r_quo[VW-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_div_n};
    assign rem_sub = rem_sh - {1'b0, r_div_n};

    // Quotient and remainder of |d|/n step the running j*|d|/n forward.
    assign acc_sum   = {1'b0, r_acc_r} + {1'b0, r_rem};
    assign acc_carry = acc_sum >= {1'b0, r_div_n};
    assign acc_sub   = acc_sum - {1'b0, r_div_n};
    assign interp_value = r_neg ? (r_base - r_acc_q) : (r_base + r_acc_q);

    assign o_status.bin_zero  = (in_v == '0);
    assign o_status.slot_free = !r_out_valid || !i_out_stall;
    assign o_status.div_done  = (r_div_cnt == '0);

    assign o_out_valid      = r_out_valid;
    assign o_filled_value   = FIELD_W'(r_out_value);
    assign o_run_last       = r_out_last;
    assign o_histogram_done = r_out_done;
    assign o_gap_abandoned  = r_out_ab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor  <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (i_is_underflow) begin
                    r_anchor <= in_v;
                end else if (i_is_last_bin) begin
                    r_anchor <= '0;
                end else if (in_v != '0) begin
                    r_anchor <= in_v;
                end
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= DCW'(VW);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bin  <= in_v;
            r_base <= r_anchor;
            r_neg  <= in_neg;
        end
        if (i_cmd.div_start) begin
            r_div_n <= i_div_n;
            r_quo   <= in_mag;
            r_rem   <= '0;
        end else if (r_div_cnt != '0) begin
            r_quo <= {r_quo[VW-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
        end
        if (i_cmd.interp_init) begin
            r_acc_q <= r_quo;
            r_acc_r <= r_rem;
        end else if (i_cmd.emit == EMIT_INTERP) begin
            r_acc_q <= r_acc_q + r_quo + VW'(acc_carry);
            r_acc_r <= acc_carry ? acc_sub[CW-1:0] : acc_sum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EMIT_NONE) begin
            r_out_last <= i_cmd.run_last;
            r_out_done <= i_cmd.done;
            r_out_ab   <= i_cmd.abandoned;
            case (i_cmd.emit)
                EMIT_INTERP: r_out_value <= interp_value;
                EMIT_SELF:   r_out_value <= r_bin;
                default:     r_out_value <= '0;
            endcase
        end
    end

endmodule
